// ----- hdl/sedh_pkg.sv -----
// Shared types, widths and constants for the serpentine error-diffusion halftoner.
// Used by every module of the block but sedh_ram; depends on nothing.
`default_nettype none

package sedh_pkg;

   // Field and register widths
   localparam int PIX_W      = 8;
   localparam int FRAC_W     = 4;
   localparam int ERR_W      = 16;
   localparam int THR_W      = 8;
   localparam int LW_W       = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_W      = 11;
   localparam int RSP_DATA_W = 8;

   // Corrected value and weighted products, signed
   localparam int CORR_W = 18;
   localparam int PROD_W = 22;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_WIDTH = 1'd1;

   // Register reset values
   localparam logic [THR_W-1:0] THR_RESET = 8'd128;
   localparam logic [LW_W-1:0]  LW_RESET  = 11'd400;

   // A white dot in units of 1/16 grey level
   localparam logic [CORR_W-1:0] WHITE_FX = 18'd4080;

   // Stored error limits
   localparam logic signed [PROD_W-1:0] ERR_MAX_X = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] ERR_MIN_X = -PROD_W'(32768);

   // Item held in the diffusion stage
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
      logic             first_row;
      logic             col_zero;
      logic             row_last;
      logic             reverse;
   } stage_ctl_type;

   // Saturate a wide signed value to a stored error
   function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [PROD_W-1:0] v);
      logic signed [ERR_W-1:0] r;
      if (v > ERR_MAX_X) begin
         r = ERR_MAX_X[ERR_W-1:0];
      end else if (v < ERR_MIN_X) begin
         r = ERR_MIN_X[ERR_W-1:0];
      end else begin
         r = v[ERR_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/sedh_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sedh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/sedh_scan.sv -----
// Scan sequencer: column count, row direction, first-row flag, memory read address,
// and the register stage feeding the diffusion datapath. Depends on sedh_pkg.
`default_nettype none

module sedh_scan #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           take,
   input  wire logic                           advance,
   input  wire logic [sedh_pkg::PIX_W-1:0]     pixel,
   input  wire logic                           frame_start,
   input  wire logic [sedh_pkg::LW_W-1:0]      line_width,
   output logic                                stage_valid,
   output sedh_pkg::stage_ctl_type             stage_ctl,
   output logic [$clog2(MAX_WIDTH)-1:0]        stage_pos,
   output logic                                rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]        rd_addr
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WW > sedh_pkg::LW_W) ? WW : sedh_pkg::LW_W;

   logic [CW-1:0]    col_ff, col_in;
   logic             rev_ff, rev_in;
   logic             first_ff, first_in;
   logic             stage_v_ff, stage_v_in;
   sedh_pkg::stage_ctl_type stage_ctl_ff;
   logic [CW-1:0]    stage_pos_ff;

   logic [CMP_W-1:0] lw_ext;
   logic [CMP_W-1:0] w_sat;
   logic [CW-1:0]    w_last;
   logic [CW-1:0]    col_eff;
   logic             rev_eff;
   logic             first_eff;
   logic [CW-1:0]    cnt;
   logic             last;
   logic [CW-1:0]    pos;

   // Clamp the row width to the supported range
   always_comb begin
      lw_ext = CMP_W'(line_width);
      if (lw_ext < CMP_W'(2)) begin
         w_sat = CMP_W'(2);
      end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
         w_sat = CMP_W'(MAX_WIDTH);
      end else begin
         w_sat = lw_ext;
      end
      w_last = CW'(w_sat - CMP_W'(1));
   end

   // Position of the incoming pixel; a frame start restarts the scan first
   always_comb begin
      col_eff   = frame_start ? '0   : col_ff;
      rev_eff   = frame_start ? 1'b0 : rev_ff;
      first_eff = frame_start ? 1'b1 : first_ff;
      cnt       = (col_eff > w_last) ? w_last : col_eff;
      last      = (cnt == w_last);
      pos       = rev_eff ? (w_last - cnt) : cnt;
   end

   // Advance the scan on each input transfer
   always_comb begin
      col_in   = col_ff;
      rev_in   = rev_ff;
      first_in = first_ff;
      if (take) begin
         if (last) begin
            col_in   = '0;
            rev_in   = ~rev_eff;
            first_in = 1'b0;
         end else begin
            col_in   = cnt + CW'(1);
            rev_in   = rev_eff;
            first_in = first_eff;
         end
      end
   end

   assign stage_v_in = take | (stage_v_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         rev_ff     <= 1'b0;
         first_ff   <= 1'b1;
         stage_v_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         rev_ff     <= rev_in;
         first_ff   <= first_in;
         stage_v_ff <= stage_v_in;
      end
   end

   // Load the diffusion stage
   always_ff @(posedge clock) begin
      if (take) begin
         stage_ctl_ff.pixel       <= pixel;
         stage_ctl_ff.frame_start <= frame_start;
         stage_ctl_ff.first_row   <= first_eff;
         stage_ctl_ff.col_zero    <= (cnt == '0);
         stage_ctl_ff.row_last    <= last;
         stage_ctl_ff.reverse     <= rev_eff;
         stage_pos_ff             <= pos;
      end
   end

   // The first column of a later row takes its error from the corner register
   assign rd_en       = take & ~first_eff & (cnt != '0);
   assign rd_addr     = pos;
   assign stage_valid = stage_v_ff;
   assign stage_ctl   = stage_ctl_ff;
   assign stage_pos   = stage_pos_ff;

endmodule

`default_nettype wire

// ----- hdl/sedh_diffuse.sv -----
// Diffusion datapath: corrects the pixel, thresholds it, splits the error into
// Floyd-Steinberg shares and writes the next-row error back. Depends on sedh_pkg.
`default_nettype none

module sedh_diffuse #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [sedh_pkg::THR_W-1:0]    threshold,
   input  wire sedh_pkg::stage_ctl_type       stage_ctl,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  stage_pos,
   input  wire logic [sedh_pkg::ERR_W-1:0]    rd_data,
   output logic                               wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]       wr_addr,
   output logic [sedh_pkg::ERR_W-1:0]         wr_data,
   output logic                               dot_on,
   output logic                               row_end
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int ERR_W  = sedh_pkg::ERR_W;
   localparam int CORR_W = sedh_pkg::CORR_W;
   localparam int PROD_W = sedh_pkg::PROD_W;
   localparam int FRAC_W = sedh_pkg::FRAC_W;

   logic signed [ERR_W-1:0] ahead_ff, ahead_in;
   logic signed [ERR_W-1:0] near_ff, near_in;
   logic signed [ERR_W-1:0] far_ff, far_in;
   logic signed [ERR_W-1:0] corner_ff;

   logic signed [ERR_W-1:0]  ahead_cur, near_cur, far_cur, below;
   logic signed [CORR_W-1:0] pix_fx, thr_fx, corr, err;
   logic                     white;
   logic signed [PROD_W-1:0] e_x, p7, p5, p3, s7, s5, s3, s1;
   logic signed [ERR_W-1:0]  behind_val, near_new, far_new, ahead_new;

   // Pending shares, dropped at a frame start
   always_comb begin
      ahead_cur = stage_ctl.frame_start ? '0 : ahead_ff;
      near_cur  = stage_ctl.frame_start ? '0 : near_ff;
      far_cur   = stage_ctl.frame_start ? '0 : far_ff;
      if (stage_ctl.first_row) begin
         below = '0;
      end else if (stage_ctl.col_zero) begin
         below = corner_ff;
      end else begin
         below = $signed(rd_data);
      end
   end

   // Correct and threshold
   always_comb begin
      pix_fx = CORR_W'({stage_ctl.pixel, {FRAC_W{1'b0}}});
      thr_fx = CORR_W'({threshold, {FRAC_W{1'b0}}});
      corr   = pix_fx + CORR_W'(ahead_cur) + CORR_W'(below);
      white  = (corr > thr_fx);
      err    = white ? (corr - $signed(sedh_pkg::WHITE_FX)) : corr;
   end

   // Weighted shares, floored by an arithmetic shift
   always_comb begin
      e_x = PROD_W'(err);
      p7  = (e_x <<< 3) - e_x;
      p5  = (e_x <<< 2) + e_x;
      p3  = (e_x <<< 1) + e_x;
      s7  = p7 >>> FRAC_W;
      s5  = p5 >>> FRAC_W;
      s3  = p3 >>> FRAC_W;
      s1  = e_x >>> FRAC_W;
      behind_val = sedh_pkg::sat_err(PROD_W'(near_cur) + s3);
      near_new   = sedh_pkg::sat_err(PROD_W'(far_cur) + s5);
      far_new    = sedh_pkg::sat_err(s1);
      ahead_new  = sedh_pkg::sat_err(s7);
   end

   // Hand the column behind its final share
   assign wr_en   = advance & ~stage_ctl.col_zero;
   assign wr_addr = stage_ctl.reverse ? (stage_pos + CW'(1)) : (stage_pos - CW'(1));
   assign wr_data = behind_val;

   // Carry shares forward; drop them at the end of a row
   always_comb begin
      ahead_in = ahead_ff;
      near_in  = near_ff;
      far_in   = far_ff;
      if (advance) begin
         if (stage_ctl.row_last) begin
            ahead_in = '0;
            near_in  = '0;
            far_in   = '0;
         end else begin
            ahead_in = ahead_new;
            near_in  = near_new;
            far_in   = far_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ahead_ff <= '0;
         near_ff  <= '0;
         far_ff   <= '0;
      end else begin
         ahead_ff <= ahead_in;
         near_ff  <= near_in;
         far_ff   <= far_in;
      end
   end

   // Hold the last column's error for the first pixel of the next row
   always_ff @(posedge clock) begin
      if (advance && stage_ctl.row_last) begin
         corner_ff <= near_new;
      end
   end

   assign dot_on  = white;
   assign row_end = stage_ctl.row_last;

endmodule

`default_nettype wire

// ----- hdl/serpentine_error_diffusion_halftone.sv -----
// Serpentine Floyd-Steinberg halftoner, top level: handshakes, registers, row memory.
// Depends on sedh_pkg, sedh_ram, sedh_scan and sedh_diffuse.
//
// Pixels enter in serpentine order (even rows left to right, odd rows right to left),
// one per transfer, with req_tuser set on the first pixel of a frame. Each yields one
// result: a white/black dot in rsp_tdata bit 0 and rsp_tlast on the last pixel of a row.
// The block takes one pixel per clock; each passes the stage register, then the output
// register, which drives rsp_tvalid. In the transfer cycle the next-row error for the
// pixel's column is read from a MAX_WIDTH-entry RAM; in the next cycle the stage corrects,
// thresholds and spreads the error, closing the carry to the following pixel within that
// cycle. When the output is held off, the input stalls once the stage and the output
// register are full. The RAM needs no clearing: the first row of each frame ignores it.
// Write threshold and line_width only while idle.
`default_nettype none

module serpentine_error_diffusion_halftone #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Pixel stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [sedh_pkg::PIX_W-1:0]           req_tdata,   // [7:0] pixel
   input  wire logic                                 req_tuser,   // [0] frame_start
   // Dot stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [sedh_pkg::RSP_DATA_W-1:0]           rsp_tdata,   // [0] dot_on, [7:1] zero
   output logic                                      rsp_tlast,   // row_end
   // Configuration writes
   input  wire logic                                 csr_we,
   input  wire logic [sedh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sedh_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [sedh_pkg::THR_W-1:0] threshold_ff, threshold_in;
   logic [sedh_pkg::LW_W-1:0]  line_width_ff, line_width_in;
   logic                       rsp_v_ff, rsp_v_in;
   logic                       rsp_dot_ff;
   logic                       rsp_last_ff;

   logic                       take;
   logic                       advance;
   logic                       stage_valid;
   sedh_pkg::stage_ctl_type    stage_ctl;
   logic [CW-1:0]              stage_pos;
   logic                       rd_en;
   logic [CW-1:0]              rd_addr;
   logic [sedh_pkg::ERR_W-1:0] rd_data;
   logic                       wr_en;
   logic [CW-1:0]              wr_addr;
   logic [sedh_pkg::ERR_W-1:0] wr_data;
   logic                       dot_on;
   logic                       row_end;

   // Configuration registers
   always_comb begin
      threshold_in  = threshold_ff;
      line_width_in = line_width_ff;
      if (csr_we) begin
         unique case (csr_index)
            sedh_pkg::REG_THRESHOLD:  threshold_in  = csr_wdata[sedh_pkg::THR_W-1:0];
            sedh_pkg::REG_LINE_WIDTH: line_width_in = csr_wdata[sedh_pkg::LW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= sedh_pkg::THR_RESET;
         line_width_ff <= sedh_pkg::LW_RESET;
      end else begin
         threshold_ff  <= threshold_in;
         line_width_ff <= line_width_in;
      end
   end

   // Transfer control: the stage moves on when the output register is free or being taken
   assign advance    = stage_valid & (~rsp_v_ff | rsp_tready);
   assign req_tready = ~stage_valid | advance;
   assign take       = req_tvalid & req_tready;

   sedh_scan #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .advance     (advance),
      .pixel       (req_tdata),
      .frame_start (req_tuser),
      .line_width  (line_width_ff),
      .stage_valid (stage_valid),
      .stage_ctl   (stage_ctl),
      .stage_pos   (stage_pos),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   sedh_ram #(
      .WIDTH (sedh_pkg::ERR_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sedh_diffuse #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_diffuse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .threshold (threshold_ff),
      .stage_ctl (stage_ctl),
      .stage_pos (stage_pos),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .dot_on    (dot_on),
      .row_end   (row_end)
   );

   // Output register
   assign rsp_v_in = advance | (rsp_v_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_dot_ff  <= dot_on;
         rsp_last_ff <= row_end;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {(sedh_pkg::RSP_DATA_W - 1)'(0), rsp_dot_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Read and write of the row memory never meet on one column
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("row memory read and write hit the same column");

   // A stalled stage keeps its column and its read data
   a_stall_pos: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && !advance) |=> $stable(stage_pos))
      else $error("stalled stage lost its column");

   a_stall_data: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && !advance) |=> $stable(rd_data))
      else $error("stalled stage lost its row error");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- tb/serpentine_error_diffusion_halftone_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for serpentine_error_diffusion_halftone: serpentine pixel streams
// in, dot stream out, each dot checked against a cycle-free predictor held in a small class.
// Depends on sedh_pkg and the halftoner RTL only.

module serpentine_error_diffusion_halftone_tb;
   import sedh_pkg::*;

   localparam int MAX_WIDTH   = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_PIX  = 1220;
   localparam int BIG_PIX     = 1030;

   typedef struct packed {
      logic dot_on;
      logic row_end;
   } dot_result_type;

   // Predicts each dot from the pixels taken so far and checks the dots that come back
   class dot_predictor;
      logic [THR_W-1:0]        thr = THR_RESET;
      logic [LW_W-1:0]         lw  = LW_RESET;
      logic signed [ERR_W-1:0] row_err [MAX_WIDTH];
      logic signed [ERR_W-1:0] carry     = '0;
      logic signed [ERR_W-1:0] near_pend = '0;
      logic signed [ERR_W-1:0] far_pend  = '0;
      logic [9:0]              col       = '0;
      bit                      reverse   = 1'b0;
      bit                      first     = 1'b1;
      dot_result_type          dots_due[$];
      int                      mismatches = 0;
      int                      checked    = 0;
      int                      accepted   = 0;
      int                      frames     = 0;

      function int width();
         int w;
         w = int'(lw);
         if (w < 2) w = 2;
         if (w > MAX_WIDTH) w = MAX_WIDTH;
         return w;
      endfunction

      function logic signed [ERR_W-1:0] clip16(int v);
         if (v > 32767) return 16'sh7FFF;
         if (v < -32768) return 16'sh8000;
         return v[ERR_W-1:0];
      endfunction

      function void clear_row();
         carry     = '0;
         near_pend = '0;
         far_pend  = '0;
         col       = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            REG_THRESHOLD:  thr = val[THR_W-1:0];
            REG_LINE_WIDTH: lw  = val[LW_W-1:0];
            default: ;
         endcase
      endfunction

      // Correct, threshold and spread the error of one accepted pixel
      function void note_pixel(logic [PIX_W-1:0] pix, logic frame_start);
         int             w, cnt, pos, below, corr, err, s7, s3, s5, s1, behind;
         bit             last, white;
         dot_result_type res;
         w = width();
         accepted++;
         if (frame_start) begin
            clear_row();
            reverse = 1'b0;
            first   = 1'b1;
            frames++;
         end
         cnt = int'(col);
         if (cnt > w - 1) cnt = w - 1;
         last  = (cnt == w - 1);
         pos   = reverse ? (w - 1 - cnt) : cnt;
         below = first ? 0 : int'(row_err[pos]);
         corr  = int'(pix) * 16 + int'(carry) + below;
         white = corr > int'(thr) * 16;
         err   = corr - (white ? int'(WHITE_FX) : 0);
         // Floor each weighted share
         s7 = (7 * err) >>> FRAC_W;
         s3 = (3 * err) >>> FRAC_W;
         s5 = (5 * err) >>> FRAC_W;
         s1 = err >>> FRAC_W;
         // Close out the column behind with its 3/16 share
         if (cnt > 0) begin
            behind = reverse ? pos + 1 : pos - 1;
            if (behind < w) row_err[behind] = clip16(int'(near_pend) + s3);
         end
         near_pend = clip16(int'(far_pend) + s5);
         far_pend  = clip16(s1);
         carry     = clip16(s7);
         res.dot_on  = white;
         res.row_end = last;
         dots_due.push_back(res);
         if (last) begin
            row_err[pos] = near_pend;
            clear_row();
            reverse = !reverse;
            first   = 1'b0;
         end else begin
            col = 10'(cnt + 1);
         end
      endfunction

      task report(string what);
         $display("MISMATCH at dot %0d: %s", checked, what);
         mismatches++;
      endtask

      // Compare one dot transfer with the oldest expectation
      task check_dot(logic [RSP_DATA_W-1:0] data, logic row_end);
         dot_result_type exp_dot;
         if (dots_due.size() == 0) begin
            report("dot transfer with no pixel pending");
         end else begin
            exp_dot = dots_due.pop_front();
            if (data[0] !== exp_dot.dot_on)
               report($sformatf("dot_on %b, predicted %b", data[0], exp_dot.dot_on));
            if (row_end !== exp_dot.row_end)
               report($sformatf("row_end %b, predicted %b", row_end, exp_dot.row_end));
            if (data[RSP_DATA_W-1:1] !== '0)
               report($sformatf("padding bits %b not zero", data[RSP_DATA_W-1:1]));
         end
         checked++;
      endtask
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [PIX_W-1:0]     req_tdata  = '0;   // [7:0] pixel
   logic                 req_tuser  = 1'b0; // [0] frame_start
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [0] dot_on, [7:1] zero
   logic                 rsp_tlast;         // row_end
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   dot_predictor sb = new;
   bit           hold_off_req = 1'b0;
   int           cycles       = 0;
   int           widest       = 0;

   serpentine_error_diffusion_halftone #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d dots outstanding", cycles, sb.dots_due.size());
         $display("FAIL serpentine_error_diffusion_halftone");
         $finish;
      end
   end

   // Dot receiver: check each transfer, stall at random, hold off once on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_dot(rsp_tdata, rsp_tlast);
         if (hold_off_req) begin
            stall_left   = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (sb.checked >= 500 && sb.checked < 800) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 30);
         end
      end
   end

   // Offer one pixel, with random gaps ahead of it, and hold until the transfer
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic frame_start);
      while (!(sb.accepted >= 500 && sb.accepted < 800) && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(pix, frame_start);
   endtask

   // Stop offering and wait until every predicted dot has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.dots_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, only while the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
      if (idx == REG_LINE_WIDTH && sb.width() > widest) widest = sb.width();
      @(posedge clock);
   endtask

   // Pixel content: uniform, noisy grey, near-extremes or flat grey
   function automatic logic [PIX_W-1:0] next_pixel(input int style, input int base);
      int v;
      case (style)
         0: v = $urandom_range(255);
         1: v = base + $urandom_range(16) - 8;
         2: v = ($urandom_range(99) < 20) ? $urandom_range(255) : ($urandom_range(1) ? 255 : 0);
         default: v = base;
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return PIX_W'(v);
   endfunction

   initial begin
      int   random_done, phase, w, n, style, base, r;
      bit   new_frame;
      logic fs;
      random_done = 0;
      phase       = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings, first frame without a frame start
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd128, 1'b0);
      drain();

      // Width 0 saturates to 2; lowest threshold; second row reads stored error
      write_reg(REG_THRESHOLD, CSR_W'(0));
      write_reg(REG_LINE_WIDTH, CSR_W'(0));
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd1, 1'b0);
      drain();

      // Width 1 saturates to 2; highest threshold
      write_reg(REG_THRESHOLD, CSR_W'(255));
      write_reg(REG_LINE_WIDTH, CSR_W'(1));
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      drain();

      // Width above the maximum saturates to MAX_WIDTH
      write_reg(REG_THRESHOLD, CSR_W'(128));
      write_reg(REG_LINE_WIDTH, CSR_W'(2047));
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd60, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd90, 1'b0);
      send_pixel(8'd170, 1'b0);
      drain();

      // Shrink the width inside the first row: the next pixel ends the row
      write_reg(REG_LINE_WIDTH, CSR_W'(3));
      send_pixel(8'd30, 1'b0);
      send_pixel(8'd250, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd129, 1'b0);
      // Frame start in the middle of a row
      send_pixel(8'd77, 1'b0);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0);

      // Random phases of whole and partial rows, each started from idle
      while (random_done < RANDOM_PIX) begin
         drain();
         if (phase == 0 || $urandom_range(2) == 0) begin
            r = $urandom_range(99);
            write_reg(REG_THRESHOLD, (r < 10) ? CSR_W'(0) :
                                     (r < 20) ? CSR_W'(255) : CSR_W'($urandom_range(255)));
         end
         style = $urandom_range(3);
         base  = $urandom_range(255);
         if (phase == 1) begin
            // One full maximum-width row and the start of its reverse row, under back-pressure
            write_reg(REG_LINE_WIDTH, CSR_W'(MAX_WIDTH));
            hold_off_req = 1'b1;
            for (int i = 0; i < BIG_PIX; i++) begin
               send_pixel(next_pixel(style, base), i == 0);
               random_done++;
            end
         end else begin
            new_frame = 1'b0;
            if (phase == 0 || sb.width() > 64 || $urandom_range(1) == 0) begin
               r = $urandom_range(99);
               write_reg(REG_LINE_WIDTH, (r < 8)  ? CSR_W'($urandom_range(1)) :
                                         (r < 14) ? CSR_W'(2) : CSR_W'($urandom_range(48, 3)));
               new_frame = 1'b1;
            end
            w  = sb.width();
            n  = $urandom_range(6, 1) * w + $urandom_range(w - 1);
            if (phase != 0 && n > RANDOM_PIX - random_done) n = RANDOM_PIX - random_done;
            fs = new_frame || ($urandom_range(1) == 0);
            for (int i = 0; i < n; i++) begin
               send_pixel(next_pixel(style, base), (i == 0) ? fs : ($urandom_range(99) < 2));
               random_done++;
            end
         end
         phase++;
      end

      drain();
      repeat (16) @(posedge clock);
      $display("Covered %0d pixels in %0d frames, widths 2 to %0d, %0d dots checked.",
               sb.accepted, sb.frames, widest, sb.checked);
      $display("Thresholds 0 to 255, mid-row frame starts, a first-row width cut, long stall.");
      if (sb.mismatches == 0 && sb.dots_due.size() == 0) begin
         $display("PASS serpentine_error_diffusion_halftone");
      end else begin
         $display("FAIL serpentine_error_diffusion_halftone");
      end
      $finish;
   end

endmodule
